[hw/rtl/fixed_schema_json_checker_core_macros.svh]
// assertion macros shared by the checker rtl
`ifndef FIXED_SCHEMA_JSON_CHECKER_CORE_MACROS_SVH
`define FIXED_SCHEMA_JSON_CHECKER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSJC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsjc same-cycle check failed");

// next-cycle implication, checked outside reset
`define FSJC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsjc next-cycle check failed");

`endif

[hw/rtl/fsjc_pkg.sv]
`default_nettype none

package fsjc_pkg;

  localparam logic [1:0] V_UNDECIDED = 2'd0;
  localparam logic [1:0] V_VALID     = 2'd1;
  localparam logic [1:0] V_INVALID   = 2'd2;

  localparam logic [4:0] PH_OPEN        = 5'd0;
  localparam logic [4:0] PH_KEY_EMP     = 5'd1;
  localparam logic [4:0] PH_COLON_EMP   = 5'd2;
  localparam logic [4:0] PH_BRACKET     = 5'd3;
  localparam logic [4:0] PH_ARR_FIRST   = 5'd4;
  localparam logic [4:0] PH_KEY_FIRST   = 5'd5;
  localparam logic [4:0] PH_COLON_FIRST = 5'd6;
  localparam logic [4:0] PH_VAL1_OPEN   = 5'd7;
  localparam logic [4:0] PH_VAL1_BODY   = 5'd8;
  localparam logic [4:0] PH_COMMA       = 5'd9;
  localparam logic [4:0] PH_KEY_LAST    = 5'd10;
  localparam logic [4:0] PH_COLON_LAST  = 5'd11;
  localparam logic [4:0] PH_VAL2_OPEN   = 5'd12;
  localparam logic [4:0] PH_VAL2_BODY   = 5'd13;
  localparam logic [4:0] PH_OBJ_CLOSE   = 5'd14;
  localparam logic [4:0] PH_CONTINUE    = 5'd15;
  localparam logic [4:0] PH_NEXT_OBJ    = 5'd16;
  localparam logic [4:0] PH_FINAL       = 5'd17;

  localparam logic [1:0] KEY_EMP   = 2'd0;
  localparam logic [1:0] KEY_FIRST = 2'd1;
  localparam logic [1:0] KEY_LAST  = 2'd2;

  localparam logic [3:0] KEY_EMP_LEN   = 4'd11;
  localparam logic [3:0] KEY_FIRST_LEN = 4'd11;
  localparam logic [3:0] KEY_LAST_LEN  = 4'd10;

  typedef struct packed {
    logic [4:0] phase;
    logic [3:0] kpos;
    logic [1:0] verdict;
    logic       vstart;
  } fsjc_state_t;

  localparam fsjc_state_t STATE_RESET = '{phase: PH_OPEN, kpos: 4'd0,
                                          verdict: V_UNDECIDED, vstart: 1'b0};

  function automatic logic [7:0] key_emp_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h22;
      4'd1:    b = "e";
      4'd2:    b = "m";
      4'd3:    b = "p";
      4'd4:    b = "l";
      4'd5:    b = "o";
      4'd6:    b = "y";
      4'd7:    b = "e";
      4'd8:    b = "e";
      4'd9:    b = "s";
      4'd10:   b = 8'h22;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] key_first_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h22;
      4'd1:    b = "f";
      4'd2:    b = "i";
      4'd3:    b = "r";
      4'd4:    b = "s";
      4'd5:    b = "t";
      4'd6:    b = "N";
      4'd7:    b = "a";
      4'd8:    b = "m";
      4'd9:    b = "e";
      4'd10:   b = 8'h22;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] key_last_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h22;
      4'd1:    b = "l";
      4'd2:    b = "a";
      4'd3:    b = "s";
      4'd4:    b = "t";
      4'd5:    b = "N";
      4'd6:    b = "a";
      4'd7:    b = "m";
      4'd8:    b = "e";
      4'd9:    b = 8'h22;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] key_byte(input logic [1:0] sel, input logic [3:0] pos);
    logic [7:0] b;
    unique case (sel)
      KEY_EMP:   b = key_emp_byte(pos);
      KEY_FIRST: b = key_first_byte(pos);
      KEY_LAST:  b = key_last_byte(pos);
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] key_len(input logic [1:0] sel);
    logic [3:0] n;
    unique case (sel)
      KEY_EMP:   n = KEY_EMP_LEN;
      KEY_FIRST: n = KEY_FIRST_LEN;
      KEY_LAST:  n = KEY_LAST_LEN;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fsjc_byte_if.sv]
`default_nettype none

interface fsjc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

[hw/rtl/fsjc_result_if.sv]
`default_nettype none

interface fsjc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       text_done;

  modport source (output valid, output verdict, output text_done, input ready);
  modport sink (input valid, input verdict, input text_done, output ready);
endinterface

`default_nettype wire

[hw/rtl/fsjc_step.sv]
`default_nettype none

module fsjc_step
  import fsjc_pkg::*;
(
  input  fsjc_state_t cur,
  input  logic [7:0]  data_byte,
  input  logic        end_of_text,
  output fsjc_state_t nxt,
  output logic [1:0]  verdict
);

  logic       letter;
  logic       digit;
  logic [7:0] lower;
  logic [1:0] key_sel;
  logic [4:0] key_done_phase;
  logic [3:0] kpos_inc;
  logic       key_ok;
  fsjc_state_t adv;

  assign lower  = data_byte | 8'h20;
  assign letter = (lower >= "a") && (lower <= "z");
  assign digit  = (data_byte >= "0") && (data_byte <= "9");

  always_comb begin
    key_sel        = KEY_EMP;
    key_done_phase = PH_COLON_EMP;
    if (cur.phase == PH_KEY_FIRST) begin
      key_sel        = KEY_FIRST;
      key_done_phase = PH_COLON_FIRST;
    end else if (cur.phase == PH_KEY_LAST) begin
      key_sel        = KEY_LAST;
      key_done_phase = PH_COLON_LAST;
    end
  end

  assign kpos_inc = cur.kpos + 4'd1;
  assign key_ok   = (cur.kpos < key_len(key_sel)) && (data_byte == key_byte(key_sel, cur.kpos));

  always_comb begin
    adv = cur;
    unique case (cur.phase) inside
      PH_OPEN: begin
        if (data_byte == "{") adv.phase = PH_KEY_EMP;
        else adv.verdict = V_INVALID;
      end
      PH_COLON_EMP: begin
        if (data_byte == ":") adv.phase = PH_BRACKET;
        else adv.verdict = V_INVALID;
      end
      PH_BRACKET: begin
        if (data_byte == "[") adv.phase = PH_ARR_FIRST;
        else adv.verdict = V_INVALID;
      end
      PH_ARR_FIRST, PH_CONTINUE: begin
        if (data_byte == "]") adv.phase = PH_FINAL;
        else if (cur.phase == PH_ARR_FIRST && data_byte == "{") adv.phase = PH_KEY_FIRST;
        else if (cur.phase == PH_CONTINUE && data_byte == ",") adv.phase = PH_NEXT_OBJ;
        else adv.verdict = V_INVALID;
      end
      PH_KEY_EMP, PH_KEY_FIRST, PH_KEY_LAST: begin
        if (!key_ok) begin
          adv.verdict = V_INVALID;
        end else if (kpos_inc == key_len(key_sel)) begin
          adv.kpos  = 4'd0;
          adv.phase = key_done_phase;
        end else begin
          adv.kpos = kpos_inc;
        end
      end
      PH_COLON_FIRST: begin
        if (data_byte == ":") adv.phase = PH_VAL1_OPEN;
        else adv.verdict = V_INVALID;
      end
      PH_COLON_LAST: begin
        if (data_byte == ":") adv.phase = PH_VAL2_OPEN;
        else adv.verdict = V_INVALID;
      end
      PH_VAL1_OPEN, PH_VAL2_OPEN: begin
        adv.vstart = 1'b0;
        if (data_byte == 8'h22) begin
          adv.phase = (cur.phase == PH_VAL1_OPEN) ? PH_VAL1_BODY : PH_VAL2_BODY;
        end else begin
          adv.verdict = V_INVALID;
        end
      end
      PH_VAL1_BODY, PH_VAL2_BODY: begin
        if (data_byte == 8'h22) begin
          if (cur.vstart) begin
            adv.vstart = 1'b0;
            adv.phase  = (cur.phase == PH_VAL1_BODY) ? PH_COMMA : PH_OBJ_CLOSE;
          end else begin
            adv.verdict = V_INVALID;
          end
        end else if (!cur.vstart) begin
          if (letter) adv.vstart = 1'b1;
          else adv.verdict = V_INVALID;
        end else if (!(letter || digit)) begin
          adv.verdict = V_INVALID;
        end
      end
      PH_COMMA: begin
        if (data_byte == ",") adv.phase = PH_KEY_LAST;
        else adv.verdict = V_INVALID;
      end
      PH_OBJ_CLOSE: begin
        if (data_byte == "}") adv.phase = PH_CONTINUE;
        else adv.verdict = V_INVALID;
      end
      PH_NEXT_OBJ: begin
        if (data_byte == "{") adv.phase = PH_KEY_FIRST;
        else adv.verdict = V_INVALID;
      end
      PH_FINAL: begin
        adv.verdict = (data_byte == "}") ? V_VALID : V_INVALID;
      end
      default: adv.verdict = V_INVALID;
    endcase
  end

  always_comb begin
    // once decided, bytes are ignored until the text ends
    nxt     = (cur.verdict == V_UNDECIDED) ? adv : cur;
    verdict = nxt.verdict;
    if (end_of_text) begin
      if (verdict == V_UNDECIDED) verdict = V_INVALID;
      nxt = STATE_RESET;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fixed_schema_json_checker_core.sv]
// each byte passes the input register, the step, then the result register
// throughput: one byte per cycle unless result_out stalls (one update per byte)
// the input register and the result register decouple the two channels
// reset (rst, synchronous, active high) empties both registers and returns
// the parser to the start of the template with the verdict undecided
`default_nettype none

`include "fixed_schema_json_checker_core_macros.svh"

module fixed_schema_json_checker_core
  import fsjc_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  fsjc_byte_if.sink       byte_in,
  fsjc_result_if.source   result_out
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        out_valid;
  logic [1:0]  out_verdict;
  logic        out_done;
  fsjc_state_t state;
  fsjc_state_t state_next;
  logic [1:0]  verdict_next;
  logic        advance;

  assign advance       = !out_valid || result_out.ready;
  assign byte_in.ready = !s1_valid || advance;

  assign result_out.valid     = out_valid;
  assign result_out.verdict   = out_verdict;
  assign result_out.text_done = out_done;

  fsjc_step u_step (
    .cur         (state),
    .data_byte   (s1_byte),
    .end_of_text (s1_last),
    .nxt         (state_next),
    .verdict     (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (byte_in.ready) begin
        s1_valid <= byte_in.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_byte <= byte_in.data_byte;
      s1_last <= byte_in.end_of_text;
    end
    if (advance && s1_valid) begin
      out_verdict <= verdict_next;
      out_done    <= s1_last;
    end
  end

  `FSJC_ASSERT_IMP(a_done_decided, out_valid && out_done, out_verdict != V_UNDECIDED)
  `FSJC_ASSERT_IMP(a_verdict_code, out_valid,
                   out_verdict == V_UNDECIDED || out_verdict == V_VALID || out_verdict == V_INVALID)
  `FSJC_ASSERT_NEXT(a_restart, advance && s1_valid && s1_last,
                    state.phase == PH_OPEN && state.verdict == V_UNDECIDED)
  `FSJC_ASSERT_NEXT(a_verdict_sticky,
                    state.verdict != V_UNDECIDED && !(advance && s1_valid && s1_last),
                    state.verdict == $past(state.verdict))

endmodule

`default_nettype wire
